FILE: rtl/amb_pkg.sv
// shared types and constants for the alpha mask border extractor
package amb_pkg;

    localparam int SIZE_W      = 11;
    localparam int SCALE_W     = 8;
    localparam int ALPHA_W     = 8;
    localparam int POS_W       = 18;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_FACTOR = 2'd2;

    localparam logic [SIZE_W-1:0]  RESET_FRAME_WIDTH  = 11'd1024;
    localparam logic [SIZE_W-1:0]  RESET_FRAME_HEIGHT = 11'd1024;
    localparam logic [SCALE_W-1:0] RESET_SCALE_FACTOR = 8'd1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [ALPHA_W-1:0] alpha;
    } t_in_word;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_out_word;

    typedef struct packed {
        logic [ALPHA_W-1:0] a_cur;
        logic [ALPHA_W-1:0] a_right;
        logic [ALPHA_W-1:0] b_cur;
        logic [ALPHA_W-1:0] b_left;
    } t_taps;

endpackage

FILE: rtl/amb_line_store.sv
// two line memories with write bypass and registered neighbor taps
module amb_line_store #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_wr_addr,
    input  logic [amb_pkg::ALPHA_W-1:0]   i_wr_alpha,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    output amb_pkg::t_taps                o_taps
);
    import amb_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [ALPHA_W-1:0] mem_a [MAX_WIDTH];
    logic [ALPHA_W-1:0] mem_b [MAX_WIDTH];
    t_taps              r_taps;
    logic [AW-1:0]      rd_right;
    logic [AW-1:0]      rd_left;

    assign rd_right = (i_rd_addr == AW'(MAX_WIDTH - 1)) ? i_rd_addr : i_rd_addr + AW'(1);
    assign rd_left  = (i_rd_addr == '0) ? i_rd_addr : i_rd_addr - AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_a[i_wr_addr] <= i_wr_alpha;
            mem_b[i_wr_addr] <= r_taps.a_cur;
        end
    end

    // read one column ahead, newest data wins on an address match
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_rd_addr == i_wr_addr) begin
            r_taps.a_cur <= i_wr_alpha;
        end else begin
            r_taps.a_cur <= mem_a[i_rd_addr];
        end
        if (i_wr_en && rd_right == i_wr_addr) begin
            r_taps.a_right <= i_wr_alpha;
        end else begin
            r_taps.a_right <= mem_a[rd_right];
        end
        if (i_wr_en && i_rd_addr == i_wr_addr) begin
            r_taps.b_cur <= r_taps.a_cur;
        end else begin
            r_taps.b_cur <= mem_b[i_rd_addr];
        end
        if (i_wr_en && rd_left == i_wr_addr) begin
            r_taps.b_left <= r_taps.a_cur;
        end else begin
            r_taps.b_left <= mem_b[rd_left];
        end
    end

    assign o_taps = r_taps;

endmodule

FILE: rtl/amb_out_queue.sv
// two-entry output register with skid stage
module amb_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  amb_pkg::t_out_word  i_word,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output amb_pkg::t_out_word  o_out_word
);
    import amb_pkg::*;

    t_out_word r_head;
    t_out_word r_skid;
    logic      r_head_valid;
    logic      r_skid_valid;
    logic      pop;

    assign pop = r_head_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_head       <= r_skid;
                r_head_valid <= 1'b1;
                r_skid_valid <= i_push;
                if (i_push) begin
                    r_skid <= i_word;
                end
            end else begin
                r_head_valid <= i_push;
                if (i_push) begin
                    r_head <= i_word;
                end
            end
        end else if (i_push) begin
            if (!r_head_valid) begin
                r_head       <= i_word;
                r_head_valid <= 1'b1;
            end else begin
                r_skid       <= i_word;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_head_valid;
    assign o_out_word  = r_head;

    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid word held without a head word");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_skid_valid) |-> pop)
        else $error("push into a full output queue");

endmodule

FILE: rtl/alpha_mask_border_extract.sv
// alpha mask border extractor top level: counters, border decision, config
// Takes one alpha word per cycle in raster order and emits, one row late, the scaled
// column and row of every border pixel (nonzero alpha on the frame edge or next to a
// zero-alpha four-neighbor). After the last row the host sends one row of flush words
// to decide it; words after that are dropped until reset or a greater height is set.
// An accepted word's result is registered in the output queue; a new word is taken every
// cycle; the input stalls only while both entries of the two-deep output queue are full.
// Two line memories of MAX_WIDTH bytes are read one column ahead, so the rate is one
// word per cycle with no bubble at row wrap. Memories need no clearing pass after reset.
// Config registers are to be written by the user only while no word is in flight, which the block leaves unchecked.
module alpha_mask_border_extract #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [amb_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [amb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  amb_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output amb_pkg::t_out_word                o_out_word
);
    import amb_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int XW  = $clog2(MAX_WIDTH + 1);
    localparam int CW0 = (SIZE_W > XW) ? SIZE_W : XW;
    localparam int CW  = (CW0 > RW) ? CW0 : RW;

    logic [SIZE_W-1:0]  r_frame_width;
    logic [SIZE_W-1:0]  r_frame_height;
    logic [SCALE_W-1:0] r_scale;
    logic [AW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [AW-1:0]      n_col;
    logic [RW-1:0]      n_row;
    logic [AW-1:0]      rd_addr;

    logic [CW-1:0]      w_cfg;
    logic [CW-1:0]      h_cfg;
    logic [CW-1:0]      w;
    logic [CW-1:0]      h;
    logic [CW-1:0]      x_inc;
    logic [CW-1:0]      row_ext;
    logic               last_col;
    logic               done;
    logic               flushing;
    logic               accept;
    logic               act;
    logic               on_edge;
    logic               interior_hit;
    logic               is_border;
    logic               push;
    logic               store_wr;
    logic [RW-1:0]      yc;
    logic [AW+SCALE_W-1:0] prod_x;
    logic [RW+SCALE_W-1:0] prod_y;
    t_taps              taps;
    t_out_word          result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_FRAME_WIDTH;
            r_frame_height <= RESET_FRAME_HEIGHT;
            r_scale        <= RESET_SCALE_FACTOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_SCALE_FACTOR: r_scale        <= SCALE_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // clamp sizes to 1..max
    assign w_cfg = CW'(r_frame_width);
    assign h_cfg = CW'(r_frame_height);
    assign w = (w_cfg == '0) ? CW'(1) : ((w_cfg > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_cfg);
    assign h = (h_cfg == '0) ? CW'(1) : ((h_cfg > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : h_cfg);

    assign x_inc    = CW'(r_col) + CW'(1);
    assign row_ext  = CW'(r_row);
    assign last_col = x_inc >= w;
    assign done     = row_ext > h;
    assign flushing = row_ext == h;

    assign accept = i_in_valid && !o_in_stall;
    assign act    = accept && !done && (flushing || i_in_word.mode == MODE_PIXEL);

    assign on_edge = (r_col == '0) || last_col || (r_row == RW'(1)) || (row_ext >= h);
    assign interior_hit = (taps.b_cur == '0) || (i_in_word.alpha == '0)
                       || (taps.b_left == '0) || (taps.a_right == '0);
    assign is_border = on_edge || interior_hit;
    assign push      = act && (r_row != '0) && (taps.a_cur != '0) && is_border;
    assign store_wr  = act && !flushing;

    assign yc     = r_row - RW'(1);
    assign prod_x = (AW+SCALE_W)'(r_col) * (AW+SCALE_W)'(r_scale);
    assign prod_y = (RW+SCALE_W)'(yc) * (RW+SCALE_W)'(r_scale);
    assign result.pos_x = POS_W'(prod_x);
    assign result.pos_y = POS_W'(prod_y);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (act) begin
            if (last_col) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    assign rd_addr = i_rst_n ? n_col : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    amb_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk      (i_clk),
        .i_wr_en    (store_wr),
        .i_wr_addr  (r_col),
        .i_wr_alpha (i_in_word.alpha),
        .i_rd_addr  (rd_addr),
        .o_taps     (taps)
    );

    amb_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_word      (result),
        .o_full      (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    a_no_result_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_row != '0))
        else $error("border result from the first row");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= AW'(MAX_WIDTH - 1))
        else $error("column counter beyond line memory");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (act && last_col) |=> (r_row == $past(r_row) + RW'(1)) && (r_col == '0))
        else $error("row did not advance at end of line");

endmodule

FILE: tb/tb_alpha_mask_border_extract.sv
// testbench for the alpha mask border extractor: scoreboard, word drivers and run sequence
module tb_alpha_mask_border_extract;
    import amb_pkg::*;

    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 12;

    localparam logic [ALPHA_W-1:0] FIRST_ROW [10] = '{
        8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h02, 8'h40
    };
    localparam logic [ALPHA_W-1:0] SECOND_ROW [10] = '{
        8'hFF, 8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h20, 8'hFF, 8'h10, 8'hFF
    };

    class border_scoreboard;
        localparam int MAX_COLS = 1024;
        localparam int MAX_ROWS = 1024;

        logic [ALPHA_W-1:0] above_row [MAX_COLS];
        logic [ALPHA_W-1:0] two_above_row [MAX_COLS];
        int unsigned        col;
        int unsigned        row;
        logic [SIZE_W-1:0]  width_reg;
        logic [SIZE_W-1:0]  height_reg;
        logic [SCALE_W-1:0] scale_reg;
        t_out_word          border_positions [$];

        function new();
            for (int i = 0; i < MAX_COLS; i++) begin
                above_row[i] = '0;
                two_above_row[i] = '0;
            end
            col = 0;
            row = 0;
            width_reg = RESET_FRAME_WIDTH;
            height_reg = RESET_FRAME_HEIGHT;
            scale_reg = RESET_SCALE_FACTOR;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned frame_w();
            return clamp_size(width_reg, MAX_COLS);
        endfunction

        function int unsigned frame_h();
            return clamp_size(height_reg, MAX_ROWS);
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg = value;
                CFG_FRAME_HEIGHT: height_reg = value;
                CFG_SCALE_FACTOR: scale_reg = value[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function void absorb_word(t_in_word w);
            int unsigned wd;
            int unsigned ht;
            int unsigned x;
            int unsigned yc;
            bit          flushing;
            bit          border;
            t_out_word   pos;
            wd = frame_w();
            ht = frame_h();
            x = col;
            if (row > ht) return;
            flushing = (row == ht);
            if (!flushing && w.mode == MODE_FLUSH) return;
            if (x >= MAX_COLS) x = MAX_COLS - 1;
            if (row > 0 && above_row[x] != 0) begin
                yc = row - 1;
                if (x == 0 || x + 1 >= wd || yc == 0 || yc + 1 >= ht) begin
                    border = 1'b1;
                end else begin
                    border = two_above_row[x] == 0 || w.alpha == 0 ||
                             two_above_row[x-1] == 0 || above_row[x+1] == 0;
                end
                if (border) begin
                    pos.pos_x = POS_W'(x * scale_reg);
                    pos.pos_y = POS_W'(yc * scale_reg);
                    border_positions.push_back(pos);
                end
            end
            if (!flushing) begin
                two_above_row[x] = above_row[x];
                above_row[x] = w.alpha;
            end
            if (x + 1 >= wd) begin
                col = 0;
                row++;
            end else begin
                col = x + 1;
            end
        endfunction

        function bit take_result(t_out_word got, output string why);
            t_out_word want;
            why = "";
            if (border_positions.size() == 0) begin
                why = $sformatf("position x=%0d y=%0d with none expected", got.pos_x, got.pos_y);
                return 1'b0;
            end
            want = border_positions.pop_front();
            if (got.pos_x !== want.pos_x)
                why = {why, $sformatf(" pos_x %0d want %0d", got.pos_x, want.pos_x)};
            if (got.pos_y !== want.pos_y)
                why = {why, $sformatf(" pos_y %0d want %0d", got.pos_y, want.pos_y)};
            return why == "";
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    t_in_word               in_word = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_word              out_word;

    border_scoreboard sb;
    int send_idle_pct = 9;
    int recv_stall_pct = 49;
    int errors = 0;
    int pixel_words = 0;
    int flush_words = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;

    alpha_mask_border_extract dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        string why;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (!sb.take_result(out_word, why)) report_mismatch(why);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task automatic push_word(input logic mode, input logic [ALPHA_W-1:0] alpha);
        t_in_word w;
        w.mode = mode;
        w.alpha = alpha;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.absorb_word(w);
        if (mode == MODE_PIXEL) pixel_words++;
        else flush_words++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.border_positions.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, value);
        cfg_writes++;
    endtask

    function automatic logic [ALPHA_W-1:0] pick_alpha(int unsigned zero_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < zero_pct) return '0;
        if (r < zero_pct + 10) return 8'hFF;
        return ALPHA_W'($urandom_range(1, 255));
    endfunction

    // widths stay within the columns written by the first two rows
    function automatic logic [CFG_DATA_W-1:0] pick_width();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return 11'd0;
        if (r < 15) return 11'd1;
        if (r < 25) return 11'd2;
        if (r < 50) return 11'd10;
        return CFG_DATA_W'($urandom_range(3, 9));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_scale();
        int unsigned r;
        logic [SCALE_W-1:0] s;
        r = $urandom_range(99);
        if (r < 10) s = 8'd0;
        else if (r < 20) s = 8'd255;
        else s = SCALE_W'($urandom);
        return {3'($urandom), s};
    endfunction

    initial begin
        int unsigned sent;
        int unsigned n;
        int unsigned zero_pct;
        int unsigned target;
        logic [CFG_DATA_W-1:0] width_val;
        logic [CFG_DATA_W-1:0] scale_val;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // first row starts at full width, then shrinks below the current column
        write_reg(CFG_FRAME_WIDTH, 11'd2047);
        write_reg(CFG_FRAME_HEIGHT, 11'd2047);
        write_reg(CFG_SCALE_FACTOR, 11'd255);
        for (int i = 0; i < 9; i++) begin
            push_word(MODE_PIXEL, FIRST_ROW[i]);
            if (i == 3) push_word(MODE_FLUSH, 8'hFF);
        end
        settle();
        write_reg(CFG_FRAME_WIDTH, 11'd4);
        push_word(MODE_PIXEL, FIRST_ROW[9]);
        settle();
        write_reg(CFG_FRAME_WIDTH, 11'd10);
        for (int i = 0; i < 10; i++) push_word(MODE_PIXEL, SECOND_ROW[i]);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES / 3) begin
                send_idle_pct = 49;
                recv_stall_pct = 9;
            end
            if (phase == 2 * PHASES / 3) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            settle();
            case (phase)
                0: begin
                    width_val = 11'd10;
                    scale_val = 11'd0;
                end
                1: begin
                    width_val = 11'd0;
                    scale_val = 11'h7FF;
                end
                2: begin
                    width_val = 11'd1;
                    scale_val = 11'd1;
                end
                default: begin
                    width_val = pick_width();
                    scale_val = pick_scale();
                end
            endcase
            if (sb.row > 700) width_val = 11'd10;
            write_reg(CFG_FRAME_WIDTH, width_val);
            write_reg(CFG_SCALE_FACTOR, scale_val);
            if (phase == 3 || $urandom_range(3) == 0)
                write_reg(CFG_FRAME_HEIGHT, $urandom_range(1) ? 11'd1024 : 11'd2047);
            case ($urandom_range(3))
                0: zero_pct = 10;
                1: zero_pct = 35;
                2: zero_pct = 60;
                default: zero_pct = 85;
            endcase
            n = $urandom_range(80, 110);
            sent = 0;
            while (sent < n) begin
                if ($urandom_range(99) < 4) begin
                    push_word(MODE_FLUSH, ALPHA_W'($urandom));
                end else begin
                    push_word(MODE_PIXEL, pick_alpha(zero_pct));
                    sent++;
                end
            end
        end

        // close the frame one row ahead, then flush and overrun it
        settle();
        target = sb.row + 1;
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(target));
        write_reg(CFG_SCALE_FACTOR, pick_scale());
        while (sb.row < target) push_word(MODE_PIXEL, pick_alpha(35));
        while (sb.row == target)
            push_word(($urandom_range(99) < 70) ? MODE_FLUSH : MODE_PIXEL, ALPHA_W'($urandom));
        repeat (6) push_word(1'($urandom), ALPHA_W'($urandom));
        settle();
        write_reg(CFG_FRAME_WIDTH, 11'd0);
        write_reg(CFG_FRAME_HEIGHT, 11'd0);
        write_reg(CFG_SCALE_FACTOR, 11'd0);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        if (sb.border_positions.size() != 0)
            report_mismatch($sformatf("%0d border positions never produced",
                                      sb.border_positions.size()));
        $display("run: %0d pixel words and %0d flush words sent, %0d border positions checked",
                 pixel_words, flush_words, results_seen);
        $display("run: %0d register writes over %0d phases, frame closed after %0d rows",
                 cfg_writes, PHASES, target);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
